### src/rmsd_pkg.sv
// Shared types and constants for the running mean / deviation block.
// Used by rmsd_ctrl, rmsd_datapath, the top level and the port checker.
`default_nettype none

package rmsd_pkg;

   // fixed field widths of the stream words
   localparam int KIND_BITS         = 2;
   localparam int SAMPLE_FIELD_BITS = 16;
   localparam int MEAN_BITS         = 24;
   localparam int DEV_BITS          = 24;
   localparam int COUNT_FIELD_BITS  = 20;
   localparam int REQ_TDATA_BITS    = 16;
   localparam int RSP_TDATA_BITS    = 72;
   localparam int RSP_TUSER_BITS    = 2;

   // request kinds carried on req_tuser
   localparam logic [KIND_BITS-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;

   // saturation limits of the result fields
   localparam logic [MEAN_BITS-1:0]        MEAN_POS_LIM  = 24'h7F_FFFF;
   localparam logic [MEAN_BITS-1:0]        MEAN_NEG_LIM  = 24'h80_0000;
   localparam logic [DEV_BITS-1:0]         DEV_MAX       = 24'hFF_FFFF;
   localparam logic [COUNT_FIELD_BITS-1:0] COUNT_OUT_MAX = 20'hF_FFFF;

   typedef enum logic [3:0] {
      DP_NOP       = 4'd0,
      DP_LOAD      = 4'd1,
      DP_MUL_STEP  = 4'd2,
      DP_SQ_INIT   = 4'd3,
      DP_ROOT_INIT = 4'd4,
      DP_ROOT_STEP = 4'd5,
      DP_DEV_INIT  = 4'd6,
      DP_DIV_STEP  = 4'd7,
      DP_MEAN_INIT = 4'd8,
      DP_FINISH    = 4'd9
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      add_take;
      logic      clear_take;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
   } dp_status_type;

endpackage

`default_nettype wire

### src/rmsd_ctrl.sv
// Sequencer for the running mean / deviation block: stream handshake and
// the step order of the shared multiply, root and divide. Uses rmsd_pkg.
`default_nettype none

module rmsd_ctrl #(
   parameter int MUL_STEPS  = 36,
   parameter int ROOT_STEPS = 44,
   parameter int DIV_STEPS  = 44
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic [rmsd_pkg::KIND_BITS-1:0] req_kind,
   output logic                                req_tready,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output rmsd_pkg::dp_cmd_type                cmd,
   input  wire rmsd_pkg::dp_status_type        status
);

   localparam int MAX_A = (MUL_STEPS > ROOT_STEPS) ? MUL_STEPS : ROOT_STEPS;
   localparam int MAX_S = (MAX_A > DIV_STEPS) ? MAX_A : DIV_STEPS;
   localparam int STW   = $clog2(MAX_S + 1);

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_LOAD      = 13'b0000000000010,
      ST_MUL_NSQ   = 13'b0000000000100,
      ST_SQ_INIT   = 13'b0000000001000,
      ST_MUL_SQ    = 13'b0000000010000,
      ST_ROOT_INIT = 13'b0000000100000,
      ST_ROOT      = 13'b0000001000000,
      ST_DEV_INIT  = 13'b0000010000000,
      ST_DIV_DEV   = 13'b0000100000000,
      ST_MEAN_INIT = 13'b0001000000000,
      ST_DIV_MEAN  = 13'b0010000000000,
      ST_FINISH    = 13'b0100000000000,
      ST_RESULT    = 13'b1000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [STW-1:0]       step_ff, step_in;
   rmsd_pkg::dp_op_type  op;
   logic                 take;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESULT);
   assign take       = req_tvalid && req_tready;

   assign cmd.op         = op;
   assign cmd.add_take   = take && (req_kind == rmsd_pkg::KIND_ADD);
   assign cmd.clear_take = take && (req_kind == rmsd_pkg::KIND_CLEAR);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      op       = rmsd_pkg::DP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (take && (req_kind == rmsd_pkg::KIND_QUERY)) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            op      = rmsd_pkg::DP_LOAD;
            step_in = '0;
            // empty store: zero fields are already loaded
            state_in = status.count_zero ? ST_RESULT : ST_MUL_NSQ;
         end
         ST_MUL_NSQ: begin
            op = rmsd_pkg::DP_MUL_STEP;
            if (step_ff == STW'(MUL_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_SQ_INIT;
            end else begin
               step_in = STW'(step_ff + 1'b1);
            end
         end
         ST_SQ_INIT: begin
            op       = rmsd_pkg::DP_SQ_INIT;
            state_in = ST_MUL_SQ;
         end
         ST_MUL_SQ: begin
            op = rmsd_pkg::DP_MUL_STEP;
            if (step_ff == STW'(MUL_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_ROOT_INIT;
            end else begin
               step_in = STW'(step_ff + 1'b1);
            end
         end
         ST_ROOT_INIT: begin
            op       = rmsd_pkg::DP_ROOT_INIT;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            op = rmsd_pkg::DP_ROOT_STEP;
            if (step_ff == STW'(ROOT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DEV_INIT;
            end else begin
               step_in = STW'(step_ff + 1'b1);
            end
         end
         ST_DEV_INIT: begin
            op       = rmsd_pkg::DP_DEV_INIT;
            state_in = ST_DIV_DEV;
         end
         ST_DIV_DEV: begin
            op = rmsd_pkg::DP_DIV_STEP;
            if (step_ff == STW'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_MEAN_INIT;
            end else begin
               step_in = STW'(step_ff + 1'b1);
            end
         end
         ST_MEAN_INIT: begin
            op       = rmsd_pkg::DP_MEAN_INIT;
            state_in = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            op = rmsd_pkg::DP_DIV_STEP;
            if (step_ff == STW'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end else begin
               step_in = STW'(step_ff + 1'b1);
            end
         end
         ST_FINISH: begin
            op       = rmsd_pkg::DP_FINISH;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

### src/rmsd_datapath.sv
// Datapath of the running mean / deviation block: accumulators, a serial
// multiplier, a restoring square root and a restoring divider. Uses rmsd_pkg.
`default_nettype none

module rmsd_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 20,
   parameter int FRAC_BITS   = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire rmsd_pkg::dp_cmd_type                   cmd,
   output rmsd_pkg::dp_status_type                     status,
   input  wire logic [rmsd_pkg::SAMPLE_FIELD_BITS-1:0] req_sample,
   output logic [rmsd_pkg::MEAN_BITS-1:0]              mean_fixed,
   output logic [rmsd_pkg::DEV_BITS-1:0]               deviation_fixed,
   output logic [rmsd_pkg::COUNT_FIELD_BITS-1:0]       sample_count,
   output logic                                        is_empty,
   output logic                                        count_saturated
);

   localparam int SW   = SAMPLE_BITS + COUNT_BITS;
   localparam int QW   = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
   localparam int PSW  = 2 * SAMPLE_BITS;
   localparam int NSQW = QW + COUNT_BITS;
   localparam int SQW  = 2 * SW;
   localparam int WW   = (NSQW > SQW) ? NSQW : SQW;
   localparam int DW   = WW + 2 * FRAC_BITS;
   localparam int RW   = (DW + 1) / 2;
   localparam int RADW = 2 * RW;
   localparam int DVW  = (SW + FRAC_BITS > RW) ? SW + FRAC_BITS : RW;
   localparam int XW   = (DVW + 1 > rmsd_pkg::MEAN_BITS + 1) ?
                         DVW + 1 : rmsd_pkg::MEAN_BITS + 1;
   localparam int CXW  = (COUNT_BITS > rmsd_pkg::COUNT_FIELD_BITS) ?
                         COUNT_BITS : rmsd_pkg::COUNT_FIELD_BITS;
   localparam int SXW  = (SAMPLE_BITS > rmsd_pkg::SAMPLE_FIELD_BITS) ?
                         SAMPLE_BITS : rmsd_pkg::SAMPLE_FIELD_BITS;

   // statistics and the one-deep square pipeline
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SW-1:0]         sum_ff, sum_in;
   logic [QW-1:0]         sumsq_ff, sumsq_in;
   logic                  sat_ff, sat_in;
   logic                  pend_ff, pend_in;
   logic [SW-1:0]         pext_ff, pext_in;
   logic [PSW-1:0]        psq_ff, psq_in;

   // query work registers
   logic                  neg_ff, neg_in;
   logic [SW-1:0]         mag_ff, mag_in;
   logic [WW-1:0]         ma_ff, ma_in;
   logic [SW-1:0]         mb_ff, mb_in;
   logic [WW-1:0]         prod_ff, prod_in;
   logic [WW-1:0]         nsq_ff, nsq_in;
   logic [RADW-1:0]       rad_ff, rad_in;
   logic [RW+1:0]         rem_ff, rem_in;
   logic [RW-1:0]         root_ff, root_in;
   logic [DVW-1:0]        dvd_ff, dvd_in;
   logic [COUNT_BITS:0]   drem_ff, drem_in;

   logic [rmsd_pkg::MEAN_BITS-1:0]        mean_ff, mean_in;
   logic [rmsd_pkg::DEV_BITS-1:0]         dev_ff, dev_in;
   logic [rmsd_pkg::COUNT_FIELD_BITS-1:0] ocnt_ff, ocnt_in;
   logic                                  oempty_ff, oempty_in;
   logic                                  osat_ff, osat_in;

   // sample decode
   logic [SXW-1:0]         samp_x;
   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] smag;
   logic [SW-1:0]          sext;
   logic [PSW-1:0]         ssq;
   logic                   full;

   // step logic
   logic [RW+1:0]          rem_sh, trial;
   logic                   root_ge;
   logic [COUNT_BITS:0]    dsh;
   logic                   div_ge;
   logic [XW-1:0]          q_x, q_rnd, lim_x, q_sat;
   logic                   round_up;
   logic [rmsd_pkg::MEAN_BITS-1:0] mean_mag;
   logic [CXW-1:0]         c_x;
   logic [rmsd_pkg::COUNT_FIELD_BITS-1:0] cnt_out;

   assign samp_x = SXW'(req_sample);
   assign raw    = samp_x[SAMPLE_BITS-1:0];
   assign smag   = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
   assign sext   = {{COUNT_BITS{raw[SAMPLE_BITS-1]}}, raw};
   assign ssq    = PSW'(smag) * PSW'(smag);
   assign full   = (cnt_ff == {COUNT_BITS{1'b1}});

   assign status.count_zero = (cnt_ff == '0);

   assign rem_sh  = {rem_ff[RW-1:0], rad_ff[RADW-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign root_ge = (rem_sh >= trial);

   assign dsh    = {drem_ff[COUNT_BITS-1:0], dvd_ff[DVW-1]};
   assign div_ge = (dsh >= {1'b0, cnt_ff});

   // round half away from zero on the magnitude: 2*rem >= count
   assign round_up = ({drem_ff, 1'b0} >= (COUNT_BITS + 2)'(cnt_ff));
   assign q_x      = XW'(dvd_ff);
   assign q_rnd    = q_x + XW'(round_up);
   assign lim_x    = XW'(neg_ff ? rmsd_pkg::MEAN_NEG_LIM : rmsd_pkg::MEAN_POS_LIM);
   assign q_sat    = (q_rnd > lim_x) ? lim_x : q_rnd;
   assign mean_mag = q_sat[rmsd_pkg::MEAN_BITS-1:0];

   assign c_x     = CXW'(cnt_ff);
   assign cnt_out = (c_x > CXW'(rmsd_pkg::COUNT_OUT_MAX)) ?
                    rmsd_pkg::COUNT_OUT_MAX : c_x[rmsd_pkg::COUNT_FIELD_BITS-1:0];

   // accumulation: square registered, then summed in the following cycle
   always_comb begin
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      sumsq_in = sumsq_ff;
      sat_in   = sat_ff;
      pend_in  = 1'b0;
      pext_in  = pext_ff;
      psq_in   = psq_ff;
      if (pend_ff) begin
         sum_in   = sum_ff + pext_ff;
         sumsq_in = sumsq_ff + QW'(psq_ff);
      end
      if (cmd.add_take) begin
         if (full) begin
            sat_in = 1'b1;
         end else begin
            cnt_in  = cnt_ff + 1'b1;
            pend_in = 1'b1;
            pext_in = sext;
            psq_in  = ssq;
         end
      end
      // clear also drops a square still in flight
      if (cmd.clear_take) begin
         cnt_in   = '0;
         sum_in   = '0;
         sumsq_in = '0;
         sat_in   = 1'b0;
      end
   end

   always_comb begin
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      prod_in   = prod_ff;
      nsq_in    = nsq_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      dvd_in    = dvd_ff;
      drem_in   = drem_ff;
      mean_in   = mean_ff;
      dev_in    = dev_ff;
      ocnt_in   = ocnt_ff;
      oempty_in = oempty_ff;
      osat_in   = osat_ff;
      case (cmd.op)
         rmsd_pkg::DP_LOAD: begin
            neg_in    = sum_ff[SW-1];
            mag_in    = sum_ff[SW-1] ? (~sum_ff + 1'b1) : sum_ff;
            ocnt_in   = cnt_out;
            oempty_in = (cnt_ff == '0);
            osat_in   = sat_ff;
            mean_in   = '0;
            dev_in    = '0;
            ma_in     = WW'(sumsq_ff);
            mb_in     = SW'(cnt_ff);
            prod_in   = '0;
         end
         rmsd_pkg::DP_MUL_STEP: begin
            // msb-first shift and add
            prod_in = (prod_ff << 1) + (mb_ff[SW-1] ? ma_ff : '0);
            mb_in   = mb_ff << 1;
         end
         rmsd_pkg::DP_SQ_INIT: begin
            nsq_in  = prod_ff;
            ma_in   = WW'(mag_ff);
            mb_in   = mag_ff;
            prod_in = '0;
         end
         rmsd_pkg::DP_ROOT_INIT: begin
            // prod holds sum^2, nsq holds n * sum of squares
            if (prod_ff <= nsq_ff) begin
               rad_in = RADW'(nsq_ff - prod_ff) << (2 * FRAC_BITS);
            end else begin
               rad_in = '0;
            end
            rem_in  = '0;
            root_in = '0;
         end
         rmsd_pkg::DP_ROOT_STEP: begin
            rem_in  = root_ge ? (rem_sh - trial) : rem_sh;
            root_in = {root_ff[RW-2:0], root_ge};
            rad_in  = rad_ff << 2;
         end
         rmsd_pkg::DP_DEV_INIT: begin
            dvd_in  = DVW'(root_ff);
            drem_in = '0;
         end
         rmsd_pkg::DP_DIV_STEP: begin
            drem_in = div_ge ? (dsh - {1'b0, cnt_ff}) : dsh;
            dvd_in  = {dvd_ff[DVW-2:0], div_ge};
         end
         rmsd_pkg::DP_MEAN_INIT: begin
            dev_in  = (q_x > XW'(rmsd_pkg::DEV_MAX)) ?
                      rmsd_pkg::DEV_MAX : q_x[rmsd_pkg::DEV_BITS-1:0];
            dvd_in  = DVW'(mag_ff) << FRAC_BITS;
            drem_in = '0;
         end
         rmsd_pkg::DP_FINISH: begin
            mean_in = neg_ff ? (~mean_mag + 1'b1) : mean_mag;
         end
         default: begin
            neg_in = neg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
         sat_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         sumsq_ff <= sumsq_in;
         sat_ff   <= sat_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pext_ff   <= pext_in;
      psq_ff    <= psq_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      prod_ff   <= prod_in;
      nsq_ff    <= nsq_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      dvd_ff    <= dvd_in;
      drem_ff   <= drem_in;
      mean_ff   <= mean_in;
      dev_ff    <= dev_in;
      ocnt_ff   <= ocnt_in;
      oempty_ff <= oempty_in;
      osat_ff   <= osat_in;
   end

   assign mean_fixed      = mean_ff;
   assign deviation_fixed = dev_ff;
   assign sample_count    = ocnt_ff;
   assign is_empty        = oempty_ff;
   assign count_saturated = osat_ff;

endmodule

`default_nettype wire

### src/running_mean_stddev.sv
// Add and clear words are taken one per cycle. A query steps through the
// bit-serial multiplier, root and divider to a valid result; on an empty
// store it goes from the load state straight to the result state.
// No word is taken while a query runs or its result waits.
// Synchronous active-high reset clears count, sums and saturation flag.
`default_nettype none

module running_mean_stddev #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 20,
   parameter int FRAC_BITS   = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [15:0] sample
   input  wire logic [rmsd_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // [1:0] kind
   input  wire logic [rmsd_pkg::KIND_BITS-1:0]       req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [23:0] mean_fixed, [47:24] deviation_fixed, [67:48] sample_count, [71:68] zero
   output logic [rmsd_pkg::RSP_TDATA_BITS-1:0]       rsp_tdata,
   // [0] is_empty, [1] count_saturated
   output logic [rmsd_pkg::RSP_TUSER_BITS-1:0]       rsp_tuser
);

   localparam int SW   = SAMPLE_BITS + COUNT_BITS;
   localparam int QW   = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
   localparam int NSQW = QW + COUNT_BITS;
   localparam int SQW  = 2 * SW;
   localparam int WW   = (NSQW > SQW) ? NSQW : SQW;
   localparam int DW   = WW + 2 * FRAC_BITS;
   localparam int RW   = (DW + 1) / 2;
   localparam int DVW  = (SW + FRAC_BITS > RW) ? SW + FRAC_BITS : RW;
   localparam int PADW = rmsd_pkg::RSP_TDATA_BITS - rmsd_pkg::MEAN_BITS
                         - rmsd_pkg::DEV_BITS - rmsd_pkg::COUNT_FIELD_BITS;

   rmsd_pkg::dp_cmd_type                  cmd;
   rmsd_pkg::dp_status_type               status;
   logic [rmsd_pkg::MEAN_BITS-1:0]        mean_fixed;
   logic [rmsd_pkg::DEV_BITS-1:0]         deviation_fixed;
   logic [rmsd_pkg::COUNT_FIELD_BITS-1:0] sample_count;
   logic                                  is_empty;
   logic                                  count_saturated;

   rmsd_ctrl #(
      .MUL_STEPS  (SW),
      .ROOT_STEPS (RW),
      .DIV_STEPS  (DVW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rmsd_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_tdata[rmsd_pkg::SAMPLE_FIELD_BITS-1:0]),
      .mean_fixed      (mean_fixed),
      .deviation_fixed (deviation_fixed),
      .sample_count    (sample_count),
      .is_empty        (is_empty),
      .count_saturated (count_saturated)
   );

   assign rsp_tdata = {{PADW{1'b0}}, sample_count, deviation_fixed, mean_fixed};
   assign rsp_tuser = {count_saturated, is_empty};

endmodule

`default_nettype wire

### src/rmsd_checker.sv
// Port-level checks for running_mean_stddev, bound to the top level.
// Depends on rmsd_pkg for field widths and request kinds.
`default_nettype none

module rmsd_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [rmsd_pkg::KIND_BITS-1:0]      req_tuser,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [rmsd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input wire logic [rmsd_pkg::RSP_TUSER_BITS-1:0] rsp_tuser
);

   localparam int FIELD_MSB = rmsd_pkg::MEAN_BITS + rmsd_pkg::DEV_BITS
                              + rmsd_pkg::COUNT_FIELD_BITS - 1;

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a waiting result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // one query at a time: no input while a result waits
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while result pending");

   // a query makes the block busy on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == rmsd_pkg::KIND_QUERY) |=> !req_tready)
      else $error("ready after query");

   // empty store reports all-zero statistics
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[FIELD_MSB:0] == '0))
      else $error("empty result with nonzero fields");

endmodule

bind running_mean_stddev rmsd_checker u_rmsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
